// ----- sv/ssd_pkg.sv -----
// Shared types, codes and the segment table of the seven-segment shift display.
// No dependencies; used by every module of the block.
package ssd_pkg;

  // Operation selector carried on the input tuser.
  localparam logic FUNC_SET     = 1'b0;
  localparam logic FUNC_REFRESH = 1'b1;

  // Result kind carried on the output tuser.
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_BIT = 1'b1;

  // Register map (byte address = 4 * index).
  localparam logic REG_COMMON_ANODE = 1'b0;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Segment table for values 0..11.
  localparam int TABLE_LEN = 12;
  localparam logic [7:0] SEG_TABLE [TABLE_LEN] = '{
    8'hBF, 8'h0B, 8'h77, 8'h5F, 8'hCB, 8'hDD,
    8'hFD, 8'h0F, 8'hFF, 8'hDF, 8'h01, 8'h41
  };

  // Classified command handed from front to back.
  typedef struct packed {
    logic       refresh;   // 1: refresh, 0: set
    logic       in_range;  // set index below digit count
    logic [7:0] idx;       // digit index as received
    logic [7:0] pattern;   // mapped segment pattern
  } ssd_cmd_t;

  // One result transaction.
  typedef struct packed {
    logic       kind;
    logic       accepted;
    logic       lane0_bit;
    logic       lane1_bit;
    logic [2:0] pair_number;
    logic [2:0] bit_number;
    logic       latch;
    logic       last;
  } ssd_res_t;

  // Map a value to its pattern; out-of-range values give a blank code.
  function automatic logic [7:0] seg_pattern(input logic [7:0] value,
                                             input logic       anode);
    logic [7:0] pat;
    pat = 8'h00;
    if (value < 8'(TABLE_LEN)) begin
      pat = SEG_TABLE[value[3:0]] ^ {8{anode}};
    end
    return pat;
  endfunction

endpackage

// ----- sv/ssd_front.sv -----
// Front end: accepts input transactions and classifies them into commands.
// Depends on ssd_pkg (command type, segment table).
module ssd_front import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic        s_tvalid_i,
  input  logic [15:0] s_tdata_i,    // [7:0] digit_index, [15:8] digit_value
  input  logic        s_tuser_i,    // func
  output logic        s_tready_o,
  input  logic        common_anode_i,
  input  logic        q_ready_i,
  output logic        push_o,
  output ssd_cmd_t    cmd_o
);

  localparam logic [7:0] DigitLimit = 8'(DIGIT_COUNT);

  logic [7:0] digit_index;
  logic [7:0] digit_value;

  assign digit_index = s_tdata_i[7:0];
  assign digit_value = s_tdata_i[15:8];

  // Handshake straight onto the queue
  assign s_tready_o = q_ready_i;
  assign push_o     = s_tvalid_i && q_ready_i;

  // Classify: operation, index range, mapped pattern
  always_comb begin
    cmd_o.refresh  = (s_tuser_i == FUNC_REFRESH);
    cmd_o.in_range = (digit_index < DigitLimit);
    cmd_o.idx      = digit_index;
    cmd_o.pattern  = seg_pattern(digit_value, common_anode_i);
  end

endmodule

// ----- sv/ssd_queue.sv -----
// Short command queue decoupling the front end from the back end.
// Depends on ssd_pkg (command type, queue depth).
module ssd_queue import ssd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ssd_cmd_t data_i,
  output logic     ready_o,
  input  logic     pop_i,
  output logic     valid_o,
  output ssd_cmd_t data_o
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  ssd_cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;

  assign ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- sv/ssd_back.sv -----
// Back end: executes set and refresh commands against the segment store
// and drives the set acknowledges and serial bit results through an output register.
// Depends on ssd_pkg (command and result types, codes).
module ssd_back import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  ssd_cmd_t q_data_i,
  output logic     pop_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output ssd_res_t m_res_o
);

  localparam int Half  = DIGIT_COUNT / 2;
  localparam int AW    = $clog2(DIGIT_COUNT);
  localparam int MemD  = 1 << AW;
  localparam int PW    = (Half > 1) ? $clog2(Half) : 1;
  localparam logic [PW-1:0] LastPair = PW'(Half - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_PRIME,
    ST_SHIFT
  } state_e;

  state_e          state_q;
  ssd_cmd_t        cmd_q;
  logic [PW-1:0]   pair_q;
  logic [2:0]      bit_q;
  logic [7:0]      sh0_q, sh1_q;
  logic            changed_q;
  logic [MemD-1:0] vld_q;
  logic            out_valid_q;
  ssd_res_t        out_q;

  logic [7:0]      mem_q [MemD];
  logic [7:0]      rd0_q, rd1_q;
  logic            rv0_q, rv1_q;

  logic            out_free;
  logic [7:0]      old_pat, rd0_eff, rd1_eff;
  logic [PW-1:0]   nxt_pair, pair_sel;
  logic [AW-1:0]   addr0, addr1;
  logic            ack_fire, wr_en, bit_fire, bit_latch, bit_last, out_load;

  // Read data, with never-written entries reading as zero
  assign rd0_eff = rd0_q & {8{rv0_q}};
  assign rd1_eff = rd1_q & {8{rv1_q}};
  assign old_pat = rd0_eff;

  assign out_free = !out_valid_q || m_ready_i;
  assign nxt_pair = (pair_q == LastPair) ? '0 : pair_q + 1'b1;
  assign pair_sel = (state_q == ST_PRIME || state_q == ST_SHIFT) ? nxt_pair : '0;

  // Read addresses: set target, or the pair being prefetched
  always_comb begin
    if (state_q == ST_IDLE) begin
      addr0 = q_data_i.idx[AW-1:0];
    end else if (state_q == ST_EXEC && !cmd_q.refresh) begin
      addr0 = cmd_q.idx[AW-1:0];
    end else begin
      addr0 = AW'(pair_sel);
    end
  end
  assign addr1 = AW'(pair_sel) + AW'(Half);

  assign pop_o     = (state_q == ST_IDLE) && q_valid_i;
  assign ack_fire  = (state_q == ST_EXEC) && !cmd_q.refresh && out_free;
  assign wr_en     = ack_fire && cmd_q.in_range && (old_pat != cmd_q.pattern);
  assign bit_fire  = (state_q == ST_SHIFT) && out_free;
  assign bit_latch = (bit_q == 3'd7);
  assign bit_last  = bit_latch && (pair_q == LastPair);
  assign out_load  = ack_fire || bit_fire;

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_q;

  // Sequencer, store flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      pair_q      <= '0;
      bit_q       <= '0;
      sh0_q       <= '0;
      sh1_q       <= '0;
      changed_q   <= 1'b1;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cmd_q   <= q_data_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (cmd_q.refresh) begin
            pair_q  <= '0;
            state_q <= changed_q ? ST_PRIME : ST_IDLE;
          end else if (out_free) begin
            out_q <= '{kind: KIND_ACK, accepted: cmd_q.in_range,
                       lane0_bit: 1'b0, lane1_bit: 1'b0,
                       pair_number: 3'd0, bit_number: 3'd0,
                       latch: 1'b0, last: 1'b1};
            if (wr_en) begin
              vld_q[addr0] <= 1'b1;
              changed_q    <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        ST_PRIME: begin
          sh0_q   <= rd0_eff;
          sh1_q   <= rd1_eff;
          bit_q   <= '0;
          state_q <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (out_free) begin
            out_q <= '{kind: KIND_BIT, accepted: 1'b0,
                       lane0_bit: sh0_q[0], lane1_bit: sh1_q[0],
                       pair_number: 3'(pair_q), bit_number: bit_q,
                       latch: bit_latch, last: bit_last};
            // Next pair is loaded after the eighth bit
            sh0_q <= bit_latch ? rd0_eff : sh0_q >> 1;
            sh1_q <= bit_latch ? rd1_eff : sh1_q >> 1;
            bit_q <= bit_q + 1'b1;  // wraps to zero after the eighth bit
            if (bit_latch) begin
              if (bit_last) begin
                changed_q <= 1'b0;
                state_q   <= ST_IDLE;
              end else begin
                pair_q <= nxt_pair;
              end
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Segment store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr0] <= cmd_q.pattern;
    end
    rd0_q <= mem_q[addr0];
    rd1_q <= mem_q[addr1];
    rv0_q <= vld_q[addr0];
    rv1_q <= vld_q[addr1];
  end

  // Final bit of a refresh returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_fire && bit_last |=> state_q == ST_IDLE)
    else $error("sequencer did not return to idle after last bit");

  // Changed flag only clears on the final bit of a refresh
  a_changed_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(changed_q) |-> $past(bit_fire && bit_last))
    else $error("changed flag cleared outside a refresh");

  // Store writes only for in-range set commands
  a_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> cmd_q.in_range && !cmd_q.refresh && state_q == ST_EXEC)
    else $error("store written by an invalid command");

  // Priming always starts a pair at bit zero
  a_prime_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PRIME |=> state_q == ST_SHIFT && bit_q == 3'd0 && pair_q == '0)
    else $error("shift did not start at pair zero bit zero");

endmodule

// ----- sv/seven_segment_shift_display_unit.sv -----
// Top level of the seven-segment shift display: APB register, front end,
// command queue and back end. Depends on ssd_pkg, ssd_front, ssd_queue, ssd_back.
//
// Channel   Dir  Handshake             Payload
// s_axis    in   tvalid/tready         tdata: digit_index, digit_value; tuser: func
// m_axis    out  tvalid/tready         tdata: accepted..latch; tuser: kind; tlast: last
// apb       in   psel/penable/pready   common_anode at byte address 0
//
// A set transaction passes the back end as dequeue with store read in idle,
// then compare and write in exec. A refresh with a changed store runs exec, prime
// and shift, one bit per cycle on the shift sequencer while output is free;
// an unchanged refresh returns from exec to idle. The back end holds output while the
// result register is not taken; the two-entry queue accepts input until it is full.
// Reset makes the store read as zero and marks it changed; common_anode resets to 1.
module seven_segment_shift_display_unit import ssd_pkg::*; #(
  parameter int DIGIT_COUNT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] digit_index, [15:8] digit_value
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] accepted, [1] lane0_bit, [2] lane1_bit,
                                      // [5:3] pair_number, [8:6] bit_number, [9] latch
  output logic        m_axis_tuser,   // [0] kind
  output logic        m_axis_tlast,   // last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     common_anode_q;
  logic     q_ready, push, pop, q_valid;
  ssd_cmd_t cmd_in, cmd_out;
  ssd_res_t res;
  logic     reg_hit;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_COMMON_ANODE);
  assign prdata  = reg_hit ? {31'b0, common_anode_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      common_anode_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      common_anode_q <= pwdata[0];
    end
  end

  ssd_front #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_front (
    .s_tvalid_i     (s_axis_tvalid),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .s_tready_o     (s_axis_tready),
    .common_anode_i (common_anode_q),
    .q_ready_i      (q_ready),
    .push_o         (push),
    .cmd_o          (cmd_in)
  );

  ssd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (cmd_out)
  );

  ssd_back #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (cmd_out),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_res_o   (res)
  );

  // Result packing
  assign m_axis_tdata = {6'b0, res.latch, res.bit_number, res.pair_number,
                         res.lane1_bit, res.lane0_bit, res.accepted};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// ----- test/seven_segment_shift_display_unit_test.sv -----
// Self-checking testbench for seven_segment_shift_display_unit: stream driver, stream monitor,
// APB register access and a cycle-free predictor of set acknowledges and shifted bit pairs.
// Depends on ssd_pkg and the seven_segment_shift_display_unit RTL.
`timescale 1ns / 100ps

module seven_segment_shift_display_unit_test;
  import ssd_pkg::*;

  localparam int DIGITS        = 8;
  localparam int HALF          = DIGITS / 2;
  localparam int SETTLE_CYCLES = 50;
  localparam int LONG_HOLD     = 400;
  localparam int MAX_REPORTS   = 10;
  localparam logic [2:0] ANODE_ADDR = 3'(4 * int'(REG_COMMON_ANODE));

  // Segment codes for values 0..11, common cathode polarity.
  localparam logic [7:0] GLYPH_CODES [12] = '{
    8'hBF, 8'h0B, 8'h77, 8'h5F, 8'hCB, 8'hDD,
    8'hFD, 8'h0F, 8'hFF, 8'hDF, 8'h01, 8'h41
  };

  typedef struct packed {
    logic       func;
    logic [7:0] idx;
    logic [7:0] val;
  } display_cmd_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  seven_segment_shift_display_unit #(
    .DIGIT_COUNT(DIGITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predictor state: mirrored digit store, dirty flag and polarity.
  logic [7:0]   digit_pattern [DIGITS] = '{default: 8'h00};
  logic         store_dirty = 1'b1;
  logic         anode_mode  = 1'b1;

  display_cmd_t command_backlog [$];
  ssd_res_t     expected_display_q [$];
  int           fault_count = 0;

  // Sender and receiver control shared with the sequence.
  logic         sender_pause = 1'b0;
  int           hold_requests = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void report_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic string fmt_result(input ssd_res_t r);
    return $sformatf("kind=%0d acc=%0d l0=%0d l1=%0d pair=%0d bit=%0d latch=%0d last=%0d",
                     r.kind, r.accepted, r.lane0_bit, r.lane1_bit, r.pair_number,
                     r.bit_number, r.latch, r.last);
  endfunction

  function automatic logic [7:0] glyph_for(input logic [7:0] value);
    if (value >= 8'd12) return 8'h00;
    return anode_mode ? ~GLYPH_CODES[value[3:0]] : GLYPH_CODES[value[3:0]];
  endfunction

  // Expected results of one accepted command, in order.
  function automatic void predict_display_command(input display_cmd_t c);
    ssd_res_t   r;
    logic [7:0] pat;
    r = '0;
    if (c.func == FUNC_SET) begin
      r.kind = KIND_ACK;
      r.last = 1'b1;
      if (int'(c.idx) < DIGITS) begin
        r.accepted = 1'b1;
        pat = glyph_for(c.val);
        if (digit_pattern[int'(c.idx)] != pat) begin
          digit_pattern[int'(c.idx)] = pat;
          store_dirty = 1'b1;
        end
      end
      expected_display_q.push_back(r);
    end else if (store_dirty) begin
      // Pairs go out LSB first, latch on the eighth bit of each pair.
      for (int p = 0; p < HALF; p++) begin
        for (int b = 0; b < 8; b++) begin
          r = '0;
          r.kind        = KIND_BIT;
          r.lane0_bit   = digit_pattern[p][b];
          r.lane1_bit   = digit_pattern[p + HALF][b];
          r.pair_number = 3'(p);
          r.bit_number  = 3'(b);
          r.latch       = (b == 7);
          r.last        = (p == HALF - 1) && (b == 7);
          expected_display_q.push_back(r);
        end
      end
      store_dirty = 1'b0;
    end
  endfunction

  // Stream driver: bursts of commands from the backlog with random gaps.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    logic         next_valid;
    display_cmd_t item;
    display_cmd_t seen;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        seen.func = s_axis_tuser;
        seen.idx  = s_axis_tdata[7:0];
        seen.val  = s_axis_tdata[15:8];
        predict_display_command(seen);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!sender_pause && command_backlog.size() > 0) begin
          item = command_backlog.pop_front();
          s_axis_tdata <= {item.val, item.idx};
          s_axis_tuser <= item.func;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Result monitor and receiver backpressure.
  int       hold_served = 0;
  int       hold_left   = 0;
  int       mode_left   = 0;
  int       rx_tick     = 0;
  rx_mode_e rx_mode     = RX_OPEN;

  always @(posedge clk_i or negedge rst_ni) begin
    ssd_res_t got;
    ssd_res_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind        = m_axis_tuser;
        got.accepted    = m_axis_tdata[0];
        got.lane0_bit   = m_axis_tdata[1];
        got.lane1_bit   = m_axis_tdata[2];
        got.pair_number = m_axis_tdata[5:3];
        got.bit_number  = m_axis_tdata[8:6];
        got.latch       = m_axis_tdata[9];
        got.last        = m_axis_tlast;
        if (expected_display_q.size() == 0) begin
          report_fault({"unexpected result: ", fmt_result(got)});
        end else begin
          want = expected_display_q.pop_front();
          if (got.kind !== want.kind || got.accepted !== want.accepted ||
              got.lane0_bit !== want.lane0_bit || got.lane1_bit !== want.lane1_bit ||
              got.pair_number !== want.pair_number || got.bit_number !== want.bit_number ||
              got.latch !== want.latch || got.last !== want.last) begin
            report_fault({"result mismatch: expected ", fmt_result(want),
                          " got ", fmt_result(got)});
          end
        end
      end
      // Long hold-off on request, otherwise a mode-based stall pattern.
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        rx_tick++;
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
          default:   m_axis_tready <= ((rx_tick % 4) == 0);
        endcase
      end
    end
  end

  // One APB transfer: setup then access, completes when pready is seen.
  task automatic apb_transfer(input logic write_en, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_common_anode(input logic mode);
    logic [31:0] rd;
    apb_transfer(1'b1, ANODE_ADDR, {31'd0, mode}, rd);
    apb_transfer(1'b0, ANODE_ADDR, 32'd0, rd);
    if (rd[0] !== mode) report_fault($sformatf("common_anode readback %0d, wrote %0d",
                                               rd[0], mode));
    anode_mode = mode;
  endtask

  task automatic queue_command(input logic func, input logic [7:0] idx,
                               input logic [7:0] val);
    display_cmd_t c;
    c.func = func;
    c.idx  = idx;
    c.val  = val;
    command_backlog.push_back(c);
  endtask

  // Mostly in-range digits and table values, some rejects and blanks.
  task automatic queue_random_commands(input int count);
    logic       func;
    logic [7:0] idx;
    logic [7:0] val;
    repeat (count) begin
      func = ($urandom_range(0, 4) == 0) ? FUNC_REFRESH : FUNC_SET;
      idx  = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(DIGITS, 255))
                                         : 8'($urandom_range(0, DIGITS - 1));
      val  = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(12, 255))
                                         : 8'($urandom_range(0, 11));
      queue_command(func, idx, val);
    end
  endtask

  // All commands accepted, all results seen, then let trailing refreshes retire.
  task automatic wait_for_drain();
    @(negedge clk_i);
    while (command_backlog.size() != 0 || s_axis_tvalid || expected_display_q.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Sequence: directed commands, then random phases at alternating polarity.
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Dirty store after reset, then an unchanged refresh.
    queue_command(FUNC_REFRESH, 8'd0, 8'd0);
    queue_command(FUNC_REFRESH, 8'd0, 8'd0);
    for (int v = 0; v < 12; v++) queue_command(FUNC_SET, 8'(v % DIGITS), 8'(v));
    // Rejected indexes, blank values and a rewrite of the same pattern.
    queue_command(FUNC_SET, 8'(DIGITS), 8'd3);
    queue_command(FUNC_SET, 8'hFF, 8'hFF);
    queue_command(FUNC_SET, 8'd3, 8'd12);
    queue_command(FUNC_SET, 8'd5, 8'hFF);
    queue_command(FUNC_SET, 8'd3, 8'd200);
    queue_command(FUNC_REFRESH, 8'hFF, 8'hFF);
    queue_command(FUNC_REFRESH, 8'd0, 8'd0);
    wait_for_drain();

    // Common cathode; long receiver hold-off, then a sender pause to empty.
    set_common_anode(1'b0);
    queue_random_commands(100);
    @(negedge clk_i);
    hold_requests++;
    while (command_backlog.size() > 60) @(negedge clk_i);
    sender_pause = 1'b1;
    while (s_axis_tvalid || expected_display_q.size() != 0) @(negedge clk_i);
    sender_pause = 1'b0;
    wait_for_drain();

    set_common_anode(1'b1);
    queue_random_commands(110);
    wait_for_drain();

    set_common_anode(1'b0);
    queue_random_commands(110);
    wait_for_drain();

    if (fault_count == 0 && expected_display_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
